FILE: sv/ffbp_pkg.sv
// ----------------------------------------------------------------------------
// ffbp_pkg
// Types and constants shared by the first-fit bin packer and its checker.
// ----------------------------------------------------------------------------
package ffbp_pkg;

  localparam logic [15:0] CAP_RESET = 16'd30;

  localparam logic [1:0] ST_PLACED   = 2'd0;
  localparam logic [1:0] ST_OVERSIZE = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [15:0] item_number;
    logic [15:0] item_size;
    logic        last_item;
  } ffbp_in_t;

  typedef struct packed {
    logic [15:0] item_tag;
    logic [5:0]  bin_index;
    logic        opened_bin;
    logic [1:0]  status;
    logic [6:0]  bins_in_use;
    logic        job_done;
  } ffbp_out_t;

endpackage

FILE: sv/first_fit_bin_packer_top.sv
// ----------------------------------------------------------------------------
// first_fit_bin_packer_top
// First-fit bin packer: scans open bins in order, places the item in the
// first one with room, or opens a new bin.
// ----------------------------------------------------------------------------
// Steps: accept, check against capacity, scan open bins in order, open a new
//   bin when a scan ends without a fit, then register the result.
// One item at a time: a new item is taken only once the last one is done; each
//   scanned bin takes one read of the bin memory through one subtractor.
// Reset clears the sequencer, bin count and output valid, and loads capacity 30.
// The bin memory is not cleared; only entries of open bins are ever compared.
module first_fit_bin_packer_top
  import ffbp_pkg::*;
#(
  parameter int MAX_BINS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ffbp_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output ffbp_out_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int BW = $clog2(MAX_BINS);
  localparam int CW = $clog2(MAX_BINS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_NEW   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [15:0] space_mem [MAX_BINS];

  logic [2:0]    state_r, state_nxt;
  logic [15:0]   cap_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [BW-1:0] idx_r, idx_nxt;
  logic [BW-1:0] bin_r, bin_nxt;
  logic          opened_r, opened_nxt;
  logic [1:0]    status_r, status_nxt;
  ffbp_in_t      item_r;
  logic [15:0]   rdata_r;
  logic [BW-1:0] raddr;
  logic          we;
  logic [BW-1:0] waddr;
  logic          out_valid_r;
  ffbp_out_t     out_r;

  logic [15:0] op;
  logic [16:0] diff;
  logic        fit;
  logic        scan_end;
  logic        has_room;
  logic        out_free;

  // shared compare/subtract unit
  assign op   = (state_r == S_SCAN) ? rdata_r : cap_r;
  assign diff = {1'b0, op} - {1'b0, item_r.item_size};
  assign fit  = ~diff[16];

  assign scan_end = (CW'(idx_r) + CW'(1)) == cnt_r;
  assign has_room = cnt_r != CW'(MAX_BINS);
  assign out_free = ~out_valid_r | ~out_stall;

  assign in_stall  = state_r != S_IDLE;
  assign cfg_ready = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    bin_nxt    = bin_r;
    opened_nxt = opened_r;
    status_nxt = status_r;
    raddr      = '0;
    we         = 1'b0;
    waddr      = BW'(cnt_r);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt  = S_CHECK;
          idx_nxt    = '0;
          bin_nxt    = '0;
          opened_nxt = 1'b0;
          status_nxt = ST_PLACED;
        end
      end
      S_CHECK: begin
        if (!fit) begin
          status_nxt = ST_OVERSIZE;
          state_nxt  = S_DONE;
        end else if (cnt_r == '0) begin
          we         = 1'b1;
          bin_nxt    = '0;
          opened_nxt = 1'b1;
          cnt_nxt    = cnt_r + CW'(1);
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        raddr = idx_r + BW'(1);
        if (fit) begin
          we        = 1'b1;
          waddr     = idx_r;
          bin_nxt   = idx_r;
          state_nxt = S_DONE;
        end else if (scan_end) begin
          state_nxt = S_NEW;
        end else begin
          idx_nxt = idx_r + BW'(1);
        end
      end
      S_NEW: begin
        if (has_room) begin
          we         = 1'b1;
          bin_nxt    = BW'(cnt_r);
          opened_nxt = 1'b1;
          cnt_nxt    = cnt_r + CW'(1);
        end else begin
          status_nxt = ST_FULL;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
          if (item_r.last_item) begin
            cnt_nxt = '0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      space_mem[waddr] <= diff[15:0];
    end
    rdata_r <= space_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CAP_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    bin_r    <= bin_nxt;
    opened_r <= opened_nxt;
    status_r <= status_nxt;
    if (state_r == S_IDLE && in_valid) begin
      item_r <= in_data;
    end
    if (state_r == S_DONE && out_free) begin
      out_r.item_tag    <= item_r.item_number;
      out_r.bin_index   <= 6'(bin_r);
      out_r.opened_bin  <= opened_r;
      out_r.status      <= status_r;
      out_r.bins_in_use <= 7'(cnt_r);
      out_r.job_done    <= item_r.last_item;
    end
  end

endmodule

FILE: sv/ffbp_checker.sv
// ----------------------------------------------------------------------------
// ffbp_checker
// Port-level checks for the first-fit bin packer, bound to the top level.
// ----------------------------------------------------------------------------
module ffbp_checker
  import ffbp_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input ffbp_out_t out_data,
  input logic      cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall && !cfg_ready)
    else $error("not busy after item accepted");

  a_reject_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_PLACED |->
      out_data.bin_index == 6'd0 && !out_data.opened_bin)
    else $error("rejected item reports a bin");

  a_open_placed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.opened_bin |-> out_data.status == ST_PLACED)
    else $error("bin opened for rejected item");

endmodule

bind first_fit_bin_packer_top ffbp_checker u_ffbp_checker (.*);

FILE: sim/tb_first_fit_bin_packer_top.sv
// ----------------------------------------------------------------------------
// tb_first_fit_bin_packer_top
// Self-checking bench for the first-fit bin packer. A scoreboard keeps its own
// bin table and capacity, predicts the placement of every accepted item and
// checks each returned result field by field. Stimulus is a short directed
// run followed by random jobs over several capacities. Both handshakes see
// random idle gaps.
// ----------------------------------------------------------------------------
module tb_first_fit_bin_packer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ffbp_pkg::*;

  localparam int MAX_BINS        = 64;
  localparam int IDLE_LIMIT      = 2000;
  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 200;

  class bin_packing_scoreboard;
    logic [15:0] capacity;
    logic [15:0] space [MAX_BINS];
    int          open_bins;
    ffbp_out_t   expected_placements[$];
    int          failures;

    function new();
      capacity  = CAP_RESET;
      open_bins = 0;
      failures  = 0;
    endfunction

    function void set_capacity(logic [15:0] value);
      capacity = value;
    endfunction

    function ffbp_out_t place_item(ffbp_in_t it);
      ffbp_out_t res;
      bit        found;
      res = '0;
      res.item_tag = it.item_number;
      res.job_done = it.last_item;
      res.status   = ST_PLACED;
      found = 1'b0;
      if (it.item_size > capacity) begin
        res.status = ST_OVERSIZE;
      end else begin
        for (int i = 0; i < open_bins && !found; i++) begin
          if (space[i] >= it.item_size) begin
            space[i]      = space[i] - it.item_size;
            res.bin_index = 6'(i);
            found         = 1'b1;
          end
        end
        if (!found) begin
          if (open_bins < MAX_BINS) begin
            res.bin_index    = 6'(open_bins);
            res.opened_bin   = 1'b1;
            space[open_bins] = capacity - it.item_size;
            open_bins++;
          end else begin
            res.status = ST_FULL;
          end
        end
      end
      res.bins_in_use = 7'(open_bins);
      if (it.last_item) open_bins = 0;
      return res;
    endfunction

    function void note_item(ffbp_in_t it);
      expected_placements.push_back(place_item(it));
    endfunction

    function void compare(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
        failures++;
      end
    endfunction

    function void check_result(ffbp_out_t got);
      ffbp_out_t exp_r;
      if (expected_placements.size() == 0) begin
        $error("unexpected result for item %0d", got.item_tag);
        failures++;
        return;
      end
      exp_r = expected_placements.pop_front();
      compare("item_tag", exp_r.item_tag, got.item_tag);
      compare("bin_index", 16'(exp_r.bin_index), 16'(got.bin_index));
      compare("opened_bin", 16'(exp_r.opened_bin), 16'(got.opened_bin));
      compare("status", 16'(exp_r.status), 16'(got.status));
      compare("bins_in_use", 16'(exp_r.bins_in_use), 16'(got.bins_in_use));
      compare("job_done", 16'(exp_r.job_done), 16'(got.job_done));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  ffbp_in_t    in_data;
  logic        out_valid;
  logic        out_stall;
  ffbp_out_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  bin_packing_scoreboard sb;
  bit src_gaps;
  bit sink_gaps;
  int idle_cycles = 0;

  always #6 clk = ~clk;

  first_fit_bin_packer_top #(
    .MAX_BINS (MAX_BINS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_size(logic [15:0] cap);
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return 16'd0;
    if (r < 14) return cap;
    if (r < 22 && cap != 16'hFFFF) return 16'($urandom_range(int'(cap) + 1, 65535));
    if (r < 40) return 16'($urandom_range(0, (int'(cap) + 3) / 4));
    return 16'($urandom_range(0, int'(cap)));
  endfunction

  function automatic logic [15:0] phase_capacity(int p);
    case (p)
      0: begin
        return 16'd1;
      end
      1: begin
        return 16'hFFFF;
      end
      2: begin
        return 16'd2;
      end
      3: begin
        return CAP_RESET;
      end
      4: begin
        return 16'($urandom_range(3, 20));
      end
      5: begin
        return 16'($urandom_range(10, 200));
      end
      6: begin
        return 16'hFFFF;
      end
      default: begin
        return 16'($urandom_range(1, 65535));
      end
    endcase
  endfunction

  // source side: valid stays high across back-to-back items
  task automatic send_item(input logic [15:0] num, input logic [15:0] size, input logic last);
    int       gap;
    ffbp_in_t it;
    gap = src_gaps ? pick_gap() : 0;
    it.item_number = num;
    it.item_size   = size;
    it.last_item   = last;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  // step the clock first so the item accepted at the previous edge is already noted
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_placements.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [15:0] value);
    while (sb.expected_placements.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [15:0] cap, input int n_items);
    int left;
    int job_len;
    int r;
    bit first_job;
    write_capacity(cap);
    src_gaps  = ($urandom_range(0, 2) != 0);
    sink_gaps = ($urandom_range(0, 2) != 0);
    left      = n_items;
    first_job = 1'b1;
    while (left > 0) begin
      r = $urandom_range(0, 99);
      // one long job per phase to push the table to full
      if (first_job) job_len = $urandom_range(150, 220);
      else if (r < 80) job_len = $urandom_range(1, 16);
      else if (r < 95) job_len = $urandom_range(17, 48);
      else job_len = $urandom_range(60, 110);
      first_job = 1'b0;
      for (int k = 0; k < job_len && left > 0; k++) begin
        send_item(16'($urandom), pick_size(cap), (k == job_len - 1) || (left == 1));
        left--;
      end
    end
    drain();
  endtask

  initial begin
    int hold;
    out_stall <= 1'b0;
    forever begin
      if (!sink_gaps || $urandom_range(0, 3) != 0) begin
        out_stall <= 1'b0;
        hold = $urandom_range(1, 8);
      end else begin
        out_stall <= 1'b1;
        hold = pick_gap();
        if (hold == 0) hold = 1;
      end
      repeat (hold) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_capacity(cfg_data);
      if (in_valid && !in_stall) sb.note_item(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
      if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset capacity: zero size, exact fit, oversize, reuse of earlier bins
    send_item(16'd0, 16'd0, 1'b0);
    send_item(16'd1, 16'd30, 1'b0);
    send_item(16'd2, 16'd31, 1'b0);
    send_item(16'hFFFF, 16'hFFFF, 1'b0);
    send_item(16'd4, 16'd0, 1'b0);
    send_item(16'd5, 16'd15, 1'b0);
    send_item(16'd6, 16'd16, 1'b0);
    send_item(16'd7, 16'd14, 1'b0);
    send_item(16'd8, 16'd1, 1'b0);
    send_item(16'd9, 16'd14, 1'b1);
    send_item(16'd10, 16'd0, 1'b1);
    drain();
    write_capacity(16'hFFFF);
    send_item(16'd11, 16'hFFFF, 1'b0);
    send_item(16'd12, 16'd0, 1'b0);
    send_item(16'd13, 16'hFFFF, 1'b1);
    drain();
    write_capacity(16'd1);
    send_item(16'd14, 16'd1, 1'b0);
    send_item(16'd15, 16'd2, 1'b0);
    send_item(16'd16, 16'd0, 1'b0);
    send_item(16'd17, 16'd1, 1'b1);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) run_phase(phase_capacity(p), ITEMS_PER_PHASE);

    while (sb.expected_placements.size() != 0) @(posedge clk);
    repeat (MAX_BINS + 8) @(posedge clk);
    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
